### rtl/sbre_pkg.sv
`timescale 1ns / 1ps

package sbre_pkg;

	localparam int SLOTS      = 1024;
	localparam int SLOT_W     = 10;
	localparam int SLOT_WORDS = (SLOTS + 31) / 32;
	localparam int WORD_W     = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);

	localparam logic [2:0] CMD_SET   = 3'd0;
	localparam logic [2:0] CMD_CLEAR = 3'd1;
	localparam logic [2:0] CMD_TEST  = 3'd2;
	localparam logic [2:0] CMD_FIND  = 3'd3;
	localparam logic [2:0] CMD_EMPTY = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO        = 2'd1;
	localparam logic [1:0] ST_NO_ROOM   = 2'd2;
	localparam logic [1:0] ST_BAD_RANGE = 2'd3;

	typedef enum logic [2:0] {
		OP_IMM,
		OP_RANGE,
		OP_TEST,
		OP_FIND,
		OP_EMPTY
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic              set_val;
		logic [1:0]        status;
		logic [WORD_W-1:0] wlo;
		logic [WORD_W-1:0] whi;
		logic [4:0]        blo;
		logic [4:0]        bhi;
	} op_t;

	function automatic logic [WORD_W-1:0] word_of(input logic [31:0] s);
		logic [31:0] w;
		w = s >> 5;
		return w[WORD_W-1:0];
	endfunction

endpackage

### rtl/sbre_front.sv
`timescale 1ns / 1ps

module sbre_front
	import sbre_pkg::*;
(
	input  logic [2:0]        cmd,
	input  logic [SLOT_W-1:0] slot_low,
	input  logic [SLOT_W-1:0] slot_high,
	output op_t               op
);

	logic [31:0] lo32;
	logic [31:0] hi32;
	logic [31:0] hic32;

	always_comb begin
		lo32  = 32'(slot_low);
		hi32  = 32'(slot_high);
		// clamp to the last slot that exists
		hic32 = (hi32 >= 32'(SLOTS)) ? 32'(SLOTS - 1) : hi32;

		op.kind    = OP_IMM;
		op.set_val = 1'b0;
		op.status  = ST_OK;
		op.wlo     = word_of(lo32);
		op.whi     = word_of(hic32);
		op.blo     = lo32[4:0];
		op.bhi     = hic32[4:0];

		case (cmd)
			CMD_SET: begin
				if (hi32 >= 32'(SLOTS)) begin
					op.status = ST_NO_ROOM;
				end else if (lo32 <= hi32) begin
					op.kind    = OP_RANGE;
					op.set_val = 1'b1;
				end
			end
			CMD_CLEAR: begin
				if (lo32 < 32'(SLOTS) && lo32 <= hic32) begin
					op.kind = OP_RANGE;
				end
			end
			CMD_TEST: begin
				if (lo32 >= 32'(SLOTS)) begin
					op.status = ST_NO;
				end else begin
					op.kind = OP_TEST;
				end
			end
			CMD_FIND: begin
				if (hi32 <= lo32) begin
					op.status = ST_BAD_RANGE;
				end else if (lo32 > hic32) begin
					op.status = ST_NO;
				end else begin
					op.kind = OP_FIND;
				end
			end
			CMD_EMPTY: begin
				op.kind = OP_EMPTY;
			end
			default: begin
				op.kind = OP_IMM;
			end
		endcase
	end

endmodule

### rtl/sbre_fifo.sv
`timescale 1ns / 1ps

module sbre_fifo
	import sbre_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	input  logic pop,
	output op_t  head,
	output logic empty,
	output logic full
);

	op_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (QPTR_W + 1)'(QDEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W + 1)'(QDEPTH))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

### rtl/sbre_back.sv
`timescale 1ns / 1ps

module sbre_back
	import sbre_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  op_t               head,
	input  logic              empty,
	output logic              pop,
	output logic              done,
	output logic [1:0]        status,
	output logic [SLOT_W-1:0] found_slot
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RANGE,
		S_FIND
	} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic [WORD_W-1:0]   cur_q;
	logic [31:0]         bits_q [SLOT_WORDS];
	logic [SLOT_WORDS-1:0] nz_q;
	logic                done_q;
	logic [1:0]          status_q;
	logic [SLOT_W-1:0]   found_q;

	logic [WORD_W-1:0] rd_idx;
	logic [31:0]       rd_word;
	logic [31:0]       mask;
	logic [31:0]       new_word;
	logic [31:0]       hits;
	logic [4:0]        top_bit;
	logic [31:0]       found32;

	function automatic logic [4:0] highest(input logic [31:0] v);
		logic [4:0] idx;
		idx = '0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) begin
				idx = 5'(i);
			end
		end
		return idx;
	endfunction

	assign pop        = (state_q == S_IDLE) && !empty;
	assign done       = done_q;
	assign status     = status_q;
	assign found_slot = found_q;

	always_comb begin
		rd_idx   = (state_q == S_IDLE) ? head.wlo : cur_q;
		rd_word  = bits_q[rd_idx];
		// trim the end words of the range to the bits inside it
		mask     = '1;
		if (cur_q == op_q.wlo) begin
			mask = mask & ('1 << op_q.blo);
		end
		if (cur_q == op_q.whi) begin
			mask = mask & ('1 >> (5'd31 - op_q.bhi));
		end
		new_word = op_q.set_val ? (rd_word | mask) : (rd_word & ~mask);
		hits     = rd_word & mask;
		top_bit  = highest(hits);
		found32  = (32'(cur_q) << 5) | 32'(top_bit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			found_q  <= '0;
			cur_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						cur_q <= (head.kind == OP_FIND) ? head.whi : head.wlo;
						case (head.kind)
							OP_IMM: begin
								done_q   <= 1'b1;
								status_q <= head.status;
								found_q  <= '0;
							end
							OP_TEST: begin
								done_q   <= 1'b1;
								status_q <= rd_word[head.blo] ? ST_OK : ST_NO;
								found_q  <= '0;
							end
							OP_EMPTY: begin
								done_q   <= 1'b1;
								status_q <= (|nz_q) ? ST_NO : ST_OK;
								found_q  <= '0;
							end
							OP_RANGE: begin
								state_q <= S_RANGE;
							end
							OP_FIND: begin
								state_q <= S_FIND;
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= ST_OK;
								found_q  <= '0;
							end
						endcase
					end
				end
				S_RANGE: begin
					if (cur_q == op_q.whi) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						found_q  <= '0;
						state_q  <= S_IDLE;
					end else begin
						cur_q <= cur_q + 1'b1;
					end
				end
				S_FIND: begin
					if (hits != '0) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						found_q  <= found32[SLOT_W-1:0];
						state_q  <= S_IDLE;
					end else if (cur_q == op_q.wlo) begin
						done_q   <= 1'b1;
						status_q <= ST_NO;
						found_q  <= '0;
						state_q  <= S_IDLE;
					end else begin
						cur_q <= cur_q - 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= head;
		end
	end

	// one word rewritten per cycle, with its non-zero flag kept alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_WORDS; i++) begin
				bits_q[i] <= '0;
			end
			nz_q <= '0;
		end else if (state_q == S_RANGE) begin
			bits_q[cur_q] <= new_word;
			nz_q[cur_q]   <= |new_word;
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == S_IDLE)
		else $error("queue popped while a command is running");

	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RANGE || state_q == S_FIND) |-> (cur_q >= op_q.wlo && cur_q <= op_q.whi))
		else $error("word walk left its range");

	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != ST_OK) |-> found_q == '0)
		else $error("found slot reported without a hit");

endmodule

### rtl/slot_bitmap_range_engine.sv
`timescale 1ns / 1ps

// slot bitmap engine: set, clear, test, find-highest and empty over a bitmap of slots
// command channel: cmd, slot_low and slot_high transfer at a rising edge with
// start high and busy low
// result channel: status and found_slot are valid for exactly one cycle while done
// is high; the receiver cannot stall, every result is taken in that cycle
// results come back in command order, one per command
// commands pass through a two-entry queue, so busy rises only when it is full
// immediate, test and empty commands: result registered as the back end pops them
// set and clear: each bitmap word touched is rewritten in turn, up to 32 words
// find: words are walked in turn downward from the high slot, up to 32
// the bitmap word loop in the back end sets the rate: no command is popped while
// one runs; short commands stream at one per cycle while the back end is idle
// reset clears the whole bitmap, the queue and the result strobe at once

module slot_bitmap_range_engine
	import sbre_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        cmd,
	input  logic [SLOT_W-1:0] slot_low,
	input  logic [SLOT_W-1:0] slot_high,
	output logic              done,
	output logic [1:0]        status,
	output logic [SLOT_W-1:0] found_slot
);

	op_t  front_op;
	op_t  head;
	logic empty;
	logic full;
	logic pop;
	logic push;

	assign busy = full;
	assign push = start && !full;

	sbre_front u_front (
		.cmd       (cmd),
		.slot_low  (slot_low),
		.slot_high (slot_high),
		.op        (front_op)
	);

	sbre_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (front_op),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.full    (full)
	);

	sbre_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.done       (done),
		.status     (status),
		.found_slot (found_slot)
	);

endmodule

### test/slot_bitmap_range_engine_test.sv
`timescale 1ns / 1ps

module slot_bitmap_range_engine_test;
	import sbre_pkg::*;

	// spare command codes: the block answers them with ST_OK and leaves the bitmap alone
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
	localparam int FIELD_MAX   = (1 << SLOT_W) - 1;
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_CMDS = 700;

	class slot_map_scoreboard;
		bit [SLOTS-1:0]    marked;
		logic [1:0]        status_due[$];
		logic [SLOT_W-1:0] found_due[$];

		function new();
			marked = '0;
		endfunction

		function int pending();
			return status_due.size();
		endfunction

		// works out the result of one accepted command and updates the bitmap copy
		function void note_command(logic [2:0] c, logic [SLOT_W-1:0] lo,
				logic [SLOT_W-1:0] hi);
			int l;
			int h;
			int s;
			bit hit;
			logic [1:0] st;
			logic [SLOT_W-1:0] fs;
			l = lo;
			h = hi;
			st = ST_OK;
			fs = '0;
			hit = 0;
			case (c)
				CMD_SET: begin
					if (h >= SLOTS)
						st = ST_NO_ROOM;
					else
						for (s = l; s <= h; s++)
							marked[s] = 1'b1;
				end
				CMD_CLEAR: begin
					if (l < SLOTS) begin
						if (h >= SLOTS)
							h = SLOTS - 1;
						for (s = l; s <= h; s++)
							marked[s] = 1'b0;
					end
				end
				CMD_TEST: begin
					st = (l < SLOTS && marked[l]) ? ST_OK : ST_NO;
				end
				CMD_FIND: begin
					if (h <= l) begin
						st = ST_BAD_RANGE;
					end else begin
						st = ST_NO;
						for (s = h; s >= l && !hit; s--) begin
							if (s < SLOTS && marked[s]) begin
								hit = 1;
								st = ST_OK;
								fs = SLOT_W'(s);
							end
						end
					end
				end
				CMD_EMPTY: begin
					st = (marked == '0) ? ST_OK : ST_NO;
				end
				default: begin
				end
			endcase
			status_due.push_back(st);
			found_due.push_back(fs);
		endfunction

		// empty string when the result matches the oldest outstanding one
		function string check_result(logic [1:0] st, logic [SLOT_W-1:0] fs);
			logic [1:0] st_exp;
			logic [SLOT_W-1:0] fs_exp;
			string msg;
			msg = "";
			if (status_due.size() == 0)
				return $sformatf("result status %0d found_slot %0d with no command outstanding",
					st, fs);
			st_exp = status_due.pop_front();
			fs_exp = found_due.pop_front();
			if (st !== st_exp)
				msg = $sformatf("status %0d, wanted %0d;", st, st_exp);
			if (fs !== fs_exp)
				msg = {msg, $sformatf(" found_slot %0d, wanted %0d", fs, fs_exp)};
			return msg;
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [2:0]        cmd;
	logic [SLOT_W-1:0] slot_low;
	logic [SLOT_W-1:0] slot_high;
	logic              done;
	logic [1:0]        status;
	logic [SLOT_W-1:0] found_slot;

	slot_map_scoreboard sb;
	int errors;
	int stall_cycles;

	slot_bitmap_range_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.slot_low  (slot_low),
		.slot_high (slot_high),
		.done      (done),
		.status    (status),
		.found_slot(found_slot)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report(input string msg);
		if (errors < 50)
			$display("%0t: mismatch: %s", $realtime, msg);
		errors++;
	endtask

	// check results before noting new transfers: a result never belongs to
	// a command taken at the same edge
	always @(posedge clk) begin : monitor
		string msg;
		if (arst_n) begin
			if (done) begin
				msg = sb.check_result(status, found_slot);
				if (msg != "")
					report(msg);
			end
			if (start && !busy)
				sb.note_command(cmd, slot_low, slot_high);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("slot_bitmap_range_engine_test NOT OK");
				$finish;
			end
		end
	end

	task automatic send(input logic [2:0] c, input int lo, input int hi, input bit gaps);
		while (gaps && $urandom_range(99) < 31) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		cmd       <= c;
		slot_low  <= SLOT_W'(lo);
		slot_high <= SLOT_W'(hi);
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// hold the command channel quiet until every result is back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic send_random(input bit gaps);
		logic [2:0] c;
		int pick;
		int lo;
		int hi;
		pick = $urandom_range(99);
		if (pick < 20)
			c = CMD_SET;
		else if (pick < 40)
			c = CMD_CLEAR;
		else if (pick < 60)
			c = CMD_TEST;
		else if (pick < 85)
			c = CMD_FIND;
		else if (pick < 93)
			c = CMD_EMPTY;
		else
			c = CMD_SPARE_FIRST + 3'($urandom_range(2));
		lo = $urandom_range(FIELD_MAX);
		case ($urandom_range(9))
			0: hi = $urandom_range(FIELD_MAX);
			1: hi = lo + $urandom_range(300);
			default: hi = lo + $urandom_range(40);
		endcase
		// searches mostly start high and walk down a fair way
		if (c == CMD_FIND && $urandom_range(3) != 0) begin
			hi = $urandom_range(FIELD_MAX);
			lo = hi - $urandom_range(200);
		end
		if (hi > FIELD_MAX)
			hi = FIELD_MAX;
		if (lo < 0)
			lo = 0;
		send(c, lo, hi, gaps);
	endtask

	initial begin
		errors    = 0;
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = CMD_SET;
		slot_low  = '0;
		slot_high = '0;
		sb        = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(CMD_EMPTY, 0, 0, 0);
		send(CMD_TEST, 0, 0, 0);
		send(CMD_FIND, 0, FIELD_MAX, 0);
		send(CMD_SET, 0, FIELD_MAX, 1);
		send(CMD_EMPTY, FIELD_MAX, FIELD_MAX, 0);
		send(CMD_TEST, FIELD_MAX, 0, 0);
		send(CMD_FIND, 0, FIELD_MAX, 1);
		send(CMD_CLEAR, 1, FIELD_MAX - 1, 0);
		send(CMD_FIND, 0, FIELD_MAX - 1, 0);
		send(CMD_FIND, 0, 0, 0);
		send(CMD_FIND, 10, 5, 1);
		send(CMD_SET, 100, 50, 0);
		send(CMD_SET, 31, 32, 0);
		send(CMD_FIND, 1, 40, 0);
		send(CMD_TEST, 31, 0, 1);
		send(CMD_CLEAR, FIELD_MAX, FIELD_MAX, 0);
		send(CMD_CLEAR, 500, 400, 0);
		send(CMD_SPARE_FIRST, FIELD_MAX, FIELD_MAX, 0);
		send(CMD_SPARE_MID, 0, FIELD_MAX, 1);
		send(CMD_SPARE_LAST, FIELD_MAX, 0, 0);
		send(CMD_SET, FIELD_MAX, FIELD_MAX, 0);
		send(CMD_FIND, FIELD_MAX - 1, FIELD_MAX, 0);
		send(CMD_CLEAR, 0, FIELD_MAX, 1);
		send(CMD_EMPTY, 0, 0, 0);
		drain();

		for (int i = 0; i < RANDOM_CMDS; i++) begin
			if (i == 450)
				drain();
			send_random(!(i >= 200 && i < 350));
		end

		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("slot_bitmap_range_engine_test OK");
		else
			$display("slot_bitmap_range_engine_test NOT OK");
		$finish;
	end

endmodule

### files.f
rtl/sbre_pkg.sv
rtl/sbre_front.sv
rtl/sbre_fifo.sv
rtl/sbre_back.sv
rtl/slot_bitmap_range_engine.sv
test/slot_bitmap_range_engine_test.sv
